@@ src/rc4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 engine package
// Shared constants and codes for the RC4 keystream engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

    // Key store depth and derived widths.
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int KEY_LEN_W = 9;

    // Permutation and counter widths.
    localparam int BYTE_W    = 8;
    localparam int DISC_W    = 12;
    localparam int CFG_W     = 12;

    // Command codes.
    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_SCHED = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_KEY_LENGTH = 1'b0;
    localparam logic CFG_DISCARD    = 1'b1;

    // Register reset values.
    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 9'd20;
    localparam logic [DISC_W-1:0]    DISCARD_RST    = 12'd1024;

endpackage

@@ src/rc4_keystream_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 keystream cipher engine
// Key store, key schedule with configurable drop, and byte-wise cipher.
// ----------------------------------------------------------------------------
// The permutation lives in a 256 x 8 synchronous memory with one read and one
// write port, so every keystream byte is a short read-modify-write sequence:
// read S[i], read S[j], write S[i] while reading the output entry, write S[j].
// A key write is taken without leaving the idle state. A data byte steps
// through the read of S[i], the read of S[j], the swap and the output step,
// and its result goes into the output register once that register is free. A
// schedule reloads the identity, runs the key mix (read, mix, swap and
// write-back) over every entry, runs the byte steps once per discarded byte
// and loads the done beat once the output register can take it. After reset
// the engine sweeps the identity into the permutation with in_stall high.
// The output register lets a finished beat wait while the next command is
// taken. Configuration writes must only be issued while the engine is idle.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher_top
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [7:0]           key_index,
    input  logic [7:0]           value,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 kind
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_INIT    = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd1;
    localparam logic [ST_W-1:0] ST_KS_RD   = 4'd2;
    localparam logic [ST_W-1:0] ST_KS_MIX  = 4'd3;
    localparam logic [ST_W-1:0] ST_KS_SWAP = 4'd4;
    localparam logic [ST_W-1:0] ST_KS_WB   = 4'd5;
    localparam logic [ST_W-1:0] ST_PR_I    = 4'd6;
    localparam logic [ST_W-1:0] ST_PR_J    = 4'd7;
    localparam logic [ST_W-1:0] ST_PR_SWAP = 4'd8;
    localparam logic [ST_W-1:0] ST_PR_OUT  = 4'd9;
    localparam logic [ST_W-1:0] ST_RESULT  = 4'd10;

    // Control state.
    logic [ST_W-1:0]      state_reg, state_next;
    logic [BYTE_W-1:0]    u_reg, u_next;
    logic [BYTE_W-1:0]    i_reg, i_next;
    logic [BYTE_W-1:0]    j_reg, j_next;
    logic                 sched_reg, sched_next;
    logic                 is_data_reg, is_data_next;
    logic [DISC_W-1:0]    disc_reg, disc_next;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [DISC_W-1:0]    discard_count_reg;
    logic                 out_valid_reg, out_valid_next;

    // Payload state.
    logic [KEY_AW-1:0]    k_reg, k_next;
    logic [KEY_LEN_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0]    a_reg, a_next;
    logic [BYTE_W-1:0]    b_reg, b_next;
    logic [BYTE_W-1:0]    t_reg, t_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [BYTE_W-1:0]    res_byte_reg, res_byte_next;
    logic                 res_kind_reg, res_kind_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 kind_reg, kind_next;

    // Memories.
    logic [BYTE_W-1:0]    perm_mem [256];
    logic [BYTE_W-1:0]    key_mem [KEY_DEPTH];
    logic                 pm_we;
    logic [BYTE_W-1:0]    pm_waddr;
    logic [BYTE_W-1:0]    pm_wdata;
    logic [BYTE_W-1:0]    pm_raddr;
    logic [BYTE_W-1:0]    pm_rdata;
    logic                 key_we;
    logic [BYTE_W-1:0]    key_rdata;

    logic                 accept;
    logic                 out_free;
    logic [KEY_LEN_W-1:0] len_sat;
    logic [KEY_LEN_W-1:0] k_inc;
    logic [BYTE_W-1:0]    j_mix;
    logic [BYTE_W-1:0]    j_step;
    logic [BYTE_W-1:0]    i_step;
    logic [BYTE_W-1:0]    t_sum;
    logic [BYTE_W-1:0]    ks_byte;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign key_we   = accept && (command == CMD_KEY)
                      && (KEY_LEN_W'(key_index) < KEY_LEN_W'(KEY_DEPTH));

    // A key length of zero acts as one; anything above the store depth saturates.
    assign len_sat = (key_length_reg == '0) ? KEY_LEN_W'(1) :
                     (key_length_reg > KEY_LEN_W'(KEY_DEPTH)) ? KEY_LEN_W'(KEY_DEPTH) :
                     key_length_reg;

    assign k_inc  = KEY_LEN_W'(k_reg) + KEY_LEN_W'(1);
    assign j_mix  = j_reg + pm_rdata + key_rdata;
    assign j_step = j_reg + pm_rdata;
    assign i_step = i_reg + 8'd1;
    assign t_sum  = a_reg + pm_rdata;

    // The output entry was read in the same cycle that S[i] was written, and
    // S[j] is written only now, so the freshest value has to be forwarded.
    assign ks_byte = (t_reg == j_reg) ? a_reg :
                     (t_reg == i_reg) ? b_reg : pm_rdata;

    always_comb
    begin
        state_next    = state_reg;
        u_next        = u_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        sched_next    = sched_reg;
        is_data_next  = is_data_reg;
        disc_next     = disc_reg;
        k_next        = k_reg;
        len_next      = len_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        t_next        = t_reg;
        data_next     = data_reg;
        res_byte_next = res_byte_reg;
        res_kind_next = res_kind_reg;
        out_byte_next = out_byte_reg;
        kind_next     = kind_reg;
        out_valid_next = out_valid_reg && out_stall;
        pm_we         = 1'b0;
        pm_waddr      = u_reg;
        pm_wdata      = u_reg;
        pm_raddr      = i_reg;

        case (state_reg)
            ST_INIT:
            begin
                pm_we    = 1'b1;
                pm_waddr = u_reg;
                pm_wdata = u_reg;
                u_next   = u_reg + 8'd1;
                if (u_reg == 8'hFF)
                begin
                    sched_next = 1'b0;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = sched_reg ? ST_KS_RD : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_SCHED:
                        begin
                            sched_next = 1'b1;
                            u_next     = '0;
                            len_next   = len_sat;
                            state_next = ST_INIT;
                        end
                        CMD_DATA:
                        begin
                            data_next    = value;
                            is_data_next = 1'b1;
                            state_next   = ST_PR_I;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KS_RD:
            begin
                pm_raddr   = u_reg;
                state_next = ST_KS_MIX;
            end
            ST_KS_MIX:
            begin
                a_next     = pm_rdata;
                j_next     = j_mix;
                pm_raddr   = j_mix;
                state_next = ST_KS_SWAP;
            end
            ST_KS_SWAP:
            begin
                pm_we      = 1'b1;
                pm_waddr   = u_reg;
                pm_wdata   = pm_rdata;
                state_next = ST_KS_WB;
            end
            ST_KS_WB:
            begin
                pm_we    = 1'b1;
                pm_waddr = j_reg;
                pm_wdata = a_reg;
                u_next   = u_reg + 8'd1;
                k_next   = (k_inc >= len_reg) ? '0 : k_inc[KEY_AW-1:0];
                if (u_reg == 8'hFF)
                begin
                    i_next        = '0;
                    j_next        = '0;
                    is_data_next  = 1'b0;
                    disc_next     = discard_count_reg;
                    res_byte_next = '0;
                    res_kind_next = KIND_DONE;
                    state_next    = (discard_count_reg == '0) ? ST_RESULT : ST_PR_I;
                end
                else
                begin
                    state_next = ST_KS_RD;
                end
            end
            ST_PR_I:
            begin
                i_next     = i_step;
                pm_raddr   = i_step;
                state_next = ST_PR_J;
            end
            ST_PR_J:
            begin
                a_next     = pm_rdata;
                j_next     = j_step;
                pm_raddr   = j_step;
                state_next = ST_PR_SWAP;
            end
            ST_PR_SWAP:
            begin
                b_next     = pm_rdata;
                t_next     = t_sum;
                pm_we      = 1'b1;
                pm_waddr   = i_reg;
                pm_wdata   = pm_rdata;
                pm_raddr   = t_sum;
                state_next = ST_PR_OUT;
            end
            ST_PR_OUT:
            begin
                pm_we    = 1'b1;
                pm_waddr = j_reg;
                pm_wdata = a_reg;
                if (is_data_reg)
                begin
                    res_byte_next = ks_byte ^ data_reg;
                    res_kind_next = KIND_DATA;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = ks_byte ^ data_reg;
                        kind_next      = KIND_DATA;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    disc_next = disc_reg - DISC_W'(1);
                    if (disc_reg == DISC_W'(1))
                    begin
                        res_byte_next = '0;
                        res_kind_next = KIND_DONE;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_PR_I;
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    kind_next      = res_kind_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            u_reg             <= '0;
            i_reg             <= '0;
            j_reg             <= '0;
            sched_reg         <= 1'b0;
            is_data_reg       <= 1'b0;
            disc_reg          <= '0;
            key_length_reg    <= KEY_LENGTH_RST;
            discard_count_reg <= DISCARD_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            u_reg         <= u_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            sched_reg     <= sched_next;
            is_data_reg   <= is_data_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_LENGTH: key_length_reg    <= cfg_data[KEY_LEN_W-1:0];
                    CFG_DISCARD:    discard_count_reg <= cfg_data[DISC_W-1:0];
                    default:        key_length_reg    <= key_length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        len_reg      <= len_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        res_byte_reg <= res_byte_next;
        res_kind_reg <= res_kind_next;
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
    end

    // Permutation memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            perm_mem[pm_waddr] <= pm_wdata;
        end
        pm_rdata <= perm_mem[pm_raddr];
    end

    // Key store: written by key beats, read at the schedule's key position.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_index[KEY_AW-1:0]] <= value;
        end
        key_rdata <= key_mem[k_reg];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;

    // A schedule-done beat never carries a data byte.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_DONE)) |-> (out_byte == '0))
        else $error("done beat carries a nonzero byte");

    // The engine only goes busy after taking a beat.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("engine went busy without an input beat");

    // The key mix leaves its loop only after the last permutation entry.
    a_ksa_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_KS_WB) && (state_next != ST_KS_RD)) |-> (u_reg == 8'hFF))
        else $error("key mix ended early");

    // A drop step never starts with the drop counter exhausted.
    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PR_I) && !is_data_reg) |-> (disc_reg != '0))
        else $error("drop step with empty counter");

endmodule
